// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the format converter RTL.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/fpcv_pkg.sv =====
// Package for the format converter: format codes, csr indexes, the input word type.
// No dependencies.
`default_nettype none
package fpcv_pkg;
   localparam logic [1:0] FMT_FP32 = 2'd0;
   localparam logic [1:0] FMT_FP16 = 2'd1;
   localparam logic [1:0] FMT_BF16 = 2'd2;
   localparam logic [1:0] FMT_BAD  = 2'd3;
   localparam logic [1:0] CSR_SRC  = 2'd0;
   localparam logic [1:0] CSR_TGT  = 2'd1;

   typedef struct packed {
      logic [1:0]  src;
      logic [1:0]  tgt;
      logic [31:0] raw;
   } fmt_word_type;
endpackage
`default_nettype wire

// ===== hw/rtl/fpcv_pipe.sv =====
// Three-stage conversion pipeline: decode to fp32, rebias exponent, format output.
// Depends on fpcv_pkg.
`default_nettype none
module fpcv_pipe (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  adv,
   input  wire                  in_valid,
   input  fpcv_pkg::fmt_word_type in_word,
   output logic                 out_valid,
   output logic [31:0]          out_bits,
   output logic [2:0]           valid_vec
);
   import fpcv_pkg::*;

   logic v1_ff, v2_ff, v3_ff;
   logic [1:0] tgt1_ff, tgt2_ff;
   logic pass1_ff, pass2_ff;
   logic [31:0] f32_ff, f32_in, pass_in;
   logic [31:0] f32b_ff;
   logic low2_ff, high2_ff;
   logic [4:0] ex2_ff;
   logic [31:0] res3_in, out_ff;
   logic [4:0] ex16;
   logic [9:0] man16;
   logic [3:0] lz;
   logic [9:0] nman;
   logic [7:0] e32;
   logic signed [9:0] ex;

   always_comb begin
      ex16 = in_word.raw[14:10];
      man16 = in_word.raw[9:0];
      lz = 4'd0;
      for (int k = 9; k >= 0; k--) begin
         if (man16[k] && lz == 4'd0) lz = 4'(10 - k);
      end
      nman = 10'(man16 << lz);
      e32 = 8'(8'd113 - {4'd0, lz});
      case (in_word.src)
         FMT_FP32: f32_in = in_word.raw;
         FMT_FP16: begin
            if (ex16 == 5'd0) begin
               if (man16 == 10'd0) f32_in = {in_word.raw[15], 31'd0};
               else f32_in = {in_word.raw[15], e32, nman, 13'd0};
            end else if (ex16 == 5'h1F) begin
               f32_in = {in_word.raw[15], 8'hFF, man16, 13'd0};
            end else begin
               f32_in = {in_word.raw[15], 8'({3'd0, ex16} + 8'd112), man16, 13'd0};
            end
         end
         FMT_BF16: f32_in = {in_word.raw[15:0], 16'd0};
         default:  f32_in = 32'd0;
      endcase
      if (in_word.tgt == FMT_BAD) pass_in = 32'd0;
      else if (in_word.src == FMT_FP32) pass_in = in_word.raw;
      else pass_in = {16'd0, in_word.raw[15:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_comb begin
      ex = 10'(signed'({2'd0, f32_ff[30:23]})) - 10'sd112;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pass1_ff <= (in_word.src == in_word.tgt) || (in_word.tgt == FMT_BAD);
         tgt1_ff <= in_word.tgt;
         f32_ff <= ((in_word.src == in_word.tgt) || (in_word.tgt == FMT_BAD))
                   ? pass_in : f32_in;
         pass2_ff <= pass1_ff;
         tgt2_ff <= tgt1_ff;
         f32b_ff <= f32_ff;
         low2_ff <= (ex <= 10'sd0);
         high2_ff <= (ex >= 10'sd31);
         ex2_ff <= ex[4:0];
         out_ff <= res3_in;
      end
   end

   always_comb begin
      if (pass2_ff) res3_in = f32b_ff;
      else begin
         case (tgt2_ff)
            FMT_FP32: res3_in = f32b_ff;
            FMT_FP16: begin
               if (low2_ff) res3_in = {16'd0, f32b_ff[31], 15'd0};
               else if (high2_ff) res3_in = {16'd0, f32b_ff[31], 15'h7C00};
               else res3_in = {16'd0, f32b_ff[31], ex2_ff, f32b_ff[22:13]};
            end
            FMT_BF16: res3_in = {16'd0, f32b_ff[31:16]};
            default:  res3_in = 32'd0;
         endcase
      end
   end

   assign out_valid = v3_ff;
   assign out_bits = out_ff;
   assign valid_vec = {v3_ff, v2_ff, v1_ff};
endmodule
`default_nettype wire

// ===== hw/rtl/fp32_fp16_bf16_converter_unit.sv =====
// Top level of the fp32/fp16/bf16 converter: csr registers and stall control.
// Depends on fpcv_pkg, fpcv_pipe and assert_macros.svh.
//   channel | dir | handshake     | payload
//   req     | in  | valid / stall | element_bits
//   rsp     | out | valid / stall | converted_bits
//   csr     | in  | valid / ready | index, data
// One word per cycle while the output is not stalled, carried through the three pipeline stages.
// Synchronous reset empties the pipe and loads fp32 source, fp16 target.
// A stalled output word holds every stage and stalls the input.
`default_nettype none
`include "assert_macros.svh"
module fp32_fp16_bf16_converter_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [31:0] req_element_bits,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [31:0] rsp_converted_bits,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [1:0]  csr_data
);
   import fpcv_pkg::*;

   logic [1:0] src_ff, tgt_ff;
   logic adv;
   logic [2:0] vv;
   fmt_word_type word;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff <= FMT_FP32;
         tgt_ff <= FMT_FP16;
      end else if (csr_valid) begin
         if (csr_index == CSR_SRC) src_ff <= csr_data;
         else if (csr_index == CSR_TGT) tgt_ff <= csr_data;
      end
   end

   // advance unless a valid output word is stalled
   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign word = '{src: src_ff, tgt: tgt_ff, raw: req_element_bits};

   fpcv_pipe u_pipe (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(req_valid),
      .in_word(word), .out_valid(rsp_valid), .out_bits(rsp_converted_bits),
      .valid_vec(vv)
   );

   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_converted_bits))
   `ASSERT_IMPL(a_stall, clock, reset, req_stall, rsp_valid && rsp_stall)
   `ASSERT_NEXT(a_flow, clock, reset, req_valid && !req_stall, vv[0])
endmodule
`default_nettype wire
